// ===== rtl/core/wmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_pkg: shared types and constants
// Field widths, register indexes, defaults and the window coordinate helper.
// ----------------------------------------------------------------------------
package wmf_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 8;
  localparam int WIN_W   = 3;
  localparam int DIM_W   = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // signed working width for window coordinates (covers dimensions up to 4096)
  localparam int CW    = 14;
  // signed offset width inside a window (-3 .. 3)
  localparam int OFF_W = 4;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_WINDOW = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  localparam logic [WIN_W-1:0] RST_WINDOW = 3'd3;
  localparam logic [DIM_W-1:0] RST_DIM    = 9'd256;

  typedef struct packed {
    logic             clear;
    logic             insert;
    logic [PIX_W-1:0] value;
  } wmf_sort_ctrl_t;

  // Mirror about the centre, then clamp into [0, lim).
  function automatic logic signed [CW-1:0] place_axis(
    input logic signed [CW-1:0] centre,
    input logic signed [CW-1:0] off,
    input logic signed [CW-1:0] lim
  );
    logic signed [CW-1:0] c;
    c = centre + off;
    if (c < 0 || c >= lim) c = centre - off;
    if (c < 0) c = '0;
    if (c >= lim) c = lim - CW'(1);
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wmf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_in_if / wmf_out_if: stream channels
// Valid/ready channels for request items and median results.
// ----------------------------------------------------------------------------
interface wmf_in_if;
  import wmf_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [PIX_W-1:0]   pixel_in;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  modport source (output valid, func, pixel_in, col, row, input ready);
  modport sink   (input valid, func, pixel_in, col, row, output ready);
endinterface

interface wmf_out_if;
  import wmf_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] median_out;
  modport source (output valid, median_out, input ready);
  modport sink   (input valid, median_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/windowed_median_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_median_filter_top: 2-D median filter over a stored frame
// Loads pixels into a frame store and returns window medians on request.
// ----------------------------------------------------------------------------
//  channel   dir  fields                        transaction
//  in_ch     in   func, pixel_in, col, row      load pixel / request median
//  out_ch    out  median_out                    one per compute request
//  cfg_*     in   cfg_index, cfg_data           register write, no wait
//
//  A load writes the pixel at the accepting edge.
//  A compute reads the window from the frame store, one read a cycle, into
//  the insertion chain; a drain state and a finish state then hand off the
//  median to the output register.
//  A finished median waits in the output register; loads continue meanwhile,
//  and the next compute holds in its last step until that register is free.
//  Reset clears control and configuration; the frame store is not cleared.
// ----------------------------------------------------------------------------
module windowed_median_filter_top #(
  parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = wmf_pkg::DEF_MAX_WINDOW
) (
  input  wire                            clk,
  input  wire                            rst_n,
  wmf_in_if.sink                         in_ch,
  wmf_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire  [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [wmf_pkg::CFG_W-1:0]      cfg_data
);
  import wmf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_GATHER, S_DRAIN, S_FINISH} state_t;

  state_t state_r;

  // configuration
  logic [WIN_W-1:0] window_size_r;
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;

  // request context
  logic signed [CW-1:0]    col_r, row_r, w_r, h_r;
  logic signed [OFF_W-1:0] dx_r, dy_r, half_r;
  logic [WIN_W-1:0]        side_r;
  logic                    rd_valid_r;
  logic                    out_valid_r;
  logic [PIX_W-1:0]        median_r;

  logic signed [CW-1:0] w_eff, h_eff, in_col, in_row, x_pos, y_pos;
  logic [WIN_W-1:0]     side_eff;
  logic                 accept, mem_we, mem_re, last_issue, finish_go;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [PIX_W-1:0]     rd_data, median;
  wmf_sort_ctrl_t       sort_ctrl;

  // saturate frame size into 1 .. maximum
  function automatic logic signed [CW-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic signed [CW-1:0] r;
    r = CW'(v);
    if (r < 1) r = CW'(1);
    if (r > CW'(maxv)) r = CW'(maxv);
    return r;
  endfunction

  assign w_eff  = eff_dim(frame_width_r, MAX_WIDTH);
  assign h_eff  = eff_dim(frame_height_r, MAX_HEIGHT);
  assign in_col = CW'(in_ch.col);
  assign in_row = CW'(in_ch.row);

  // odd side in 3 .. MAX_WINDOW
  always_comb begin
    side_eff = window_size_r;
    if (side_eff < 3'd3) side_eff = 3'd3;
    if (side_eff > WIN_W'(MAX_WINDOW)) side_eff = WIN_W'(MAX_WINDOW);
    if (!side_eff[0]) side_eff = side_eff - 3'd1;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // drop loads outside the frame
  assign mem_we  = accept && (in_ch.func == FUNC_LOAD) && (in_col < w_eff) && (in_row < h_eff);
  assign wr_addr = AW'(32'(in_ch.row) * MAX_WIDTH + 32'(in_ch.col));

  // window coordinate for the current offset
  assign x_pos = place_axis(col_r, {{(CW-OFF_W){dx_r[OFF_W-1]}}, dx_r}, w_r);
  assign y_pos = place_axis(row_r, {{(CW-OFF_W){dy_r[OFF_W-1]}}, dy_r}, h_r);
  assign mem_re  = (state_r == S_GATHER);
  assign rd_addr = AW'(32'(y_pos) * MAX_WIDTH + 32'(x_pos));
  assign last_issue = (dx_r == half_r) && (dy_r == half_r);

  // hand off the median once the output register is free
  assign finish_go = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  wmf_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (in_ch.pixel_in),
    .rd_en   (mem_re),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign sort_ctrl.clear  = accept && (in_ch.func == FUNC_COMPUTE);
  assign sort_ctrl.insert = rd_valid_r;
  assign sort_ctrl.value  = rd_data;

  wmf_sorter #(.MAX_WINDOW(MAX_WINDOW)) u_sort (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (sort_ctrl),
    .side   (side_r),
    .median (median)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.median_out = median_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= RST_WINDOW;
      frame_width_r  <= RST_DIM;
      frame_height_r <= RST_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size_r  <= cfg_data[WIN_W-1:0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: gather window, drain read, hand off median
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= mem_re;
      if (finish_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_ch.func == FUNC_COMPUTE) begin
            state_r <= S_GATHER;
            col_r   <= in_col;
            row_r   <= in_row;
            w_r     <= w_eff;
            h_r     <= h_eff;
            side_r  <= side_eff;
            half_r  <= OFF_W'(side_eff >> 1);
            dx_r    <= -OFF_W'(side_eff >> 1);
            dy_r    <= -OFF_W'(side_eff >> 1);
          end
        end
        S_GATHER: begin
          // advance across the row, then down
          if (dx_r == half_r) begin
            dx_r <= -half_r;
            dy_r <= dy_r + OFF_W'(1);
          end else begin
            dx_r <= dx_r + OFF_W'(1);
          end
          if (last_issue) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (finish_go) begin
            median_r <= median;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rd_follows_gather: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r |-> $past(state_r == S_GATHER))
    else $error("read data without a gather issue");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !mem_we)
    else $error("frame write during compute");

  a_drain_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_FINISH) && !rd_valid_r)
    else $error("drain did not complete");

endmodule

`default_nettype wire

// ===== rtl/core/wmf_frame_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_frame_mem: frame store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module wmf_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [AW-1:0]            wr_addr,
  input  wire  [wmf_pkg::PIX_W-1:0] wr_data,
  input  wire                      rd_en,
  input  wire  [AW-1:0]            rd_addr,
  output logic [wmf_pkg::PIX_W-1:0] rd_data
);
  import wmf_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wmf_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wmf_sorter: insertion sort cell chain
// Insert one pixel per cycle into an ascending chain; read the middle cell.
// ----------------------------------------------------------------------------
module wmf_sorter #(
  parameter int MAX_WINDOW = 7
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wmf_pkg::wmf_sort_ctrl_t    ctrl,
  input  wire  [wmf_pkg::WIN_W-1:0]  side,
  output logic [wmf_pkg::PIX_W-1:0]  median
);
  import wmf_pkg::*;

  localparam int N    = MAX_WINDOW * MAX_WINDOW;
  localparam int IDX3 = 4;
  localparam int IDX5 = (N > 12) ? 12 : 0;
  localparam int IDX7 = (N > 24) ? 24 : 0;

  logic [PIX_W-1:0] cell_r [N];
  logic [N-1:0]     vld_r;
  logic [N-1:0]     le;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic prev_le;
    assign le[i] = vld_r[i] && (cell_r[i] <= ctrl.value);
    if (i == 0) begin : g_first
      assign prev_le = 1'b1;
    end else begin : g_rest
      assign prev_le = le[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n || ctrl.clear) begin
        vld_r[i] <= 1'b0;
      end else if (ctrl.insert && !le[i]) begin
        if (prev_le) begin
          vld_r[i] <= 1'b1;
        end else begin
          vld_r[i] <= (i == 0) ? 1'b1 : vld_r[(i == 0) ? 0 : i-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.insert && !le[i]) begin
        // shift larger values up, drop the new one into its slot
        cell_r[i] <= prev_le ? ctrl.value : cell_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_comb begin
    case (side)
      3'd3:    median = cell_r[IDX3];
      3'd5:    median = cell_r[IDX5];
      default: median = cell_r[IDX7];
    endcase
  end

endmodule

`default_nettype wire
